// ===== rtl/cut_pkg.sv =====
package cut_pkg;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } cut_beat_t;

  typedef struct packed {
    logic [1:0] num;
    cut_beat_t  b0;
    cut_beat_t  b1;
  } cut_res_t;

  localparam logic [7:0]  CHR_END    = 8'h00;
  localparam logic [7:0]  CHR_SPACE  = 8'h20;
  localparam logic [7:0]  CHR_DASH   = 8'h2D;
  localparam logic [15:0] PAIR_YO_UC = 16'h596F;
  localparam logic [15:0] PAIR_YO_LC = 16'h796F;

  localparam logic [15:0] CODE_UC_LO  = 16'hD090;
  localparam logic [15:0] CODE_UC_HI  = 16'hD0AF;
  localparam logic [15:0] CODE_LCA_LO = 16'hD0B0;
  localparam logic [15:0] CODE_LCA_HI = 16'hD0BF;
  localparam logic [15:0] CODE_LCB_LO = 16'hD180;
  localparam logic [15:0] CODE_LCB_HI = 16'hD18F;
  localparam logic [15:0] CODE_YO_UC  = 16'hD081;
  localparam logic [15:0] CODE_YO_LC  = 16'hD191;
  localparam logic [15:0] CODE_DASH   = 16'hE280;

  localparam logic [15:0] UPPER_MAP [32] = '{
    16'h0041, 16'h0042, 16'h0056, 16'h0047, 16'h0044, 16'h0045, 16'h5A68, 16'h005A,
    16'h0049, 16'h0059, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F, 16'h0050,
    16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0046, 16'h0048, 16'h5473, 16'h4368,
    16'h5368, 16'h5368, 16'h0027, 16'h0059, 16'h0027, 16'h0045, 16'h5975, 16'h5961
  };

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

  function automatic logic [15:0] lookup(input logic [15:0] code);
    logic [4:0]  idx;
    logic [15:0] m;
    logic [15:0] r;
    r   = {8'h00, CHR_SPACE};
    idx = code[4:0] - 5'd16;
    m   = '0;
    if (code inside {[CODE_UC_LO:CODE_UC_HI]}) begin
      r = UPPER_MAP[idx];
    end else if (code inside {[CODE_LCA_LO:CODE_LCA_HI], [CODE_LCB_LO:CODE_LCB_HI]}) begin
      idx = {code[8], code[3:0]};
      m   = UPPER_MAP[idx];
      if (m[15:8] != 8'h00) begin
        r = {to_lower(m[15:8]), m[7:0]};
      end else begin
        r = {8'h00, to_lower(m[7:0])};
      end
    end else if (code == CODE_YO_UC) begin
      r = PAIR_YO_UC;
    end else if (code == CODE_YO_LC) begin
      r = PAIR_YO_LC;
    end else if (code == CODE_DASH) begin
      r = {8'h00, CHR_DASH};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cyrillic_utf8_transliterator.sv =====
// Cyrillic UTF-8 to Latin transliterator.
// Input channel: in_valid / in_stall / in_byte, one text byte per beat; a zero
// byte ends a string. A byte with bit 7 set waits for its partner byte; if that
// has bit 7 too, the pair maps to one or two Latin characters, a dash, or a space.
// Output channel: out_valid / out_stall / out_char / out_is_last, one
// character per beat; out_is_last marks the terminating zero of a string.
// Characters beyond MAX_CHARS per string are dropped; the zero always goes out.
// An accepted byte waits in the input register until the result buffer can
// load; its characters are then registered there and presented on the output.
// Throughput: one byte per cycle while each byte gives at most one character
// and the receiver does not stall; a byte that gives two characters holds off
// the next until the single output port drains the two-entry result buffer.
// Reset clears the held byte and the character count and empties both buffers; no
// beat is presented in the cycle after reset.
// When the receiver stalls, the current character holds; the input register
// fills and then in_stall rises until the result buffer drains.
module cyrillic_utf8_transliterator #(
  parameter int MAX_CHARS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_is_last
);
  import cut_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       can_load;
  logic       consume;
  cut_res_t   res;

  assign consume  = in_v_r && can_load;
  assign in_stall = in_v_r && !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (consume) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  cut_step #(
    .MAX_CHARS(MAX_CHARS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .consume(consume),
    .din    (in_byte_r),
    .res    (res)
  );

  cut_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .res        (res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_is_last(out_is_last)
  );

endmodule

// ===== rtl/cut_step.sv =====
module cut_step #(
  parameter int MAX_CHARS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              consume,
  input  logic [7:0]        din,
  output cut_pkg::cut_res_t res
);
  import cut_pkg::*;

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW:0] LIMIT = (CW + 1)'(MAX_CHARS);

  logic [7:0]    held_byte_r, held_byte_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   cnt_ext;
  logic          room0, room1;
  logic [15:0]   m;
  logic          two;
  logic          end_hit;

  always_comb begin
    cnt_ext        = {1'b0, cnt_r};
    room0          = cnt_ext < LIMIT;
    room1          = (cnt_ext + (CW + 1)'(1)) < LIMIT;
    m              = lookup({held_byte_r, din});
    two            = m[15:8] != 8'h00;
    res            = '0;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    cnt_nxt        = cnt_r;
    end_hit        = 1'b0;
    if (held_valid_r) begin
      held_byte_nxt  = 8'h00;
      held_valid_nxt = 1'b0;
      if (din[7]) begin
        if (two) begin
          res.b0.chr = m[15:8];
          res.b1.chr = m[7:0];
          res.num    = room1 ? 2'd2 : (room0 ? 2'd1 : 2'd0);
        end else begin
          res.b0.chr = m[7:0];
          res.num    = room0 ? 2'd1 : 2'd0;
        end
        cnt_nxt = cnt_r + CW'(res.num);
      end else if (din == CHR_END) begin
        end_hit = 1'b1;
        cnt_nxt = '0;
        if (room0) begin
          res.b0.chr  = held_byte_r;
          res.b1.chr  = CHR_END;
          res.b1.last = 1'b1;
          res.num     = 2'd2;
        end else begin
          res.b0.chr  = CHR_END;
          res.b0.last = 1'b1;
          res.num     = 2'd1;
        end
      end else begin
        res.b0.chr = held_byte_r;
        res.b1.chr = din;
        res.num    = room1 ? 2'd2 : (room0 ? 2'd1 : 2'd0);
        cnt_nxt    = cnt_r + CW'(res.num);
      end
    end else if (din == CHR_END) begin
      end_hit     = 1'b1;
      cnt_nxt     = '0;
      res.b0.chr  = CHR_END;
      res.b0.last = 1'b1;
      res.num     = 2'd1;
    end else if (din[7]) begin
      held_byte_nxt  = din;
      held_valid_nxt = 1'b1;
    end else begin
      res.b0.chr = din;
      res.num    = room0 ? 2'd1 : 2'd0;
      cnt_nxt    = cnt_r + CW'(res.num);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else if (consume) begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= LIMIT)
    else $error("character count above limit");

  a_held_hi: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> held_byte_r[7])
    else $error("held byte without bit 7");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    consume && end_hit |=> cnt_r == '0 && !held_valid_r)
    else $error("string end did not clear state");

endmodule

// ===== rtl/cut_obuf.sv =====
module cut_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cut_pkg::cut_res_t res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              out_is_last
);
  import cut_pkg::*;

  logic [1:0] cnt_r;
  cut_beat_t  e0_r, e1_r;
  logic       pop;

  assign pop         = (cnt_r != 2'd0) && !out_stall;
  assign can_load    = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign out_valid   = cnt_r != 2'd0;
  assign out_char    = e0_r.chr;
  assign out_is_last = e0_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res.num;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // advance the second beat once the first is taken
  always_ff @(posedge clk) begin
    if (load) begin
      e0_r <= res.b0;
      e1_r <= res.b1;
    end else if (pop) begin
      e0_r <= e1_r;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("load into occupied buffer");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("buffer count out of range");

  a_hold_two: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && out_stall |=> cnt_r == 2'd2 && $stable(e0_r) && $stable(e1_r))
    else $error("stalled beats changed");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cut_pkg::*;

  localparam int MAX_CHARS    = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 2000;

  localparam logic [8*32-1:0] LATIN_FIRST = "ABVGDEZZIYKLMNOPRSTUFHTCSS'Y'EYY";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_is_last;

  cut_beat_t  pending_chars[$];
  cut_beat_t  want;
  int         mismatches = 0;
  int         items_sent = 0;
  int         idle_cycles = 0;

  logic [7:0] held_byte = 8'h00;
  logic       held_valid = 1'b0;
  int         char_count = 0;

  logic       gaps_on = 1'b0;
  int         burst_left = 0;
  int         stall_level = 0;
  logic [15:0] stall_pat = '0;
  logic [3:0] stall_pos = '0;

  cyrillic_utf8_transliterator #(.MAX_CHARS(MAX_CHARS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_is_last(out_is_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // {first, second}; second is zero for a single character
  function automatic logic [15:0] latin_for_code(input logic [15:0] code);
    int         idx;
    logic       lower;
    logic [7:0] c0;
    logic [7:0] c1;
    idx   = -1;
    lower = 1'b0;
    if (code >= CODE_UC_LO && code <= CODE_UC_HI) begin
      idx = int'(code - CODE_UC_LO);
    end else if (code >= CODE_LCA_LO && code <= CODE_LCA_HI) begin
      idx   = int'(code - CODE_LCA_LO);
      lower = 1'b1;
    end else if (code >= CODE_LCB_LO && code <= CODE_LCB_HI) begin
      idx   = 16 + int'(code - CODE_LCB_LO);
      lower = 1'b1;
    end
    if (idx >= 0) begin
      c0 = LATIN_FIRST[8*(31-idx) +: 8];
      case (idx)
        6, 23, 24, 25: c1 = "h";
        22:            c1 = "s";
        30:            c1 = "u";
        31:            c1 = "a";
        default:       c1 = 8'h00;
      endcase
      if (lower && c0 >= "A" && c0 <= "Z") begin
        c0 = c0 | 8'h20;
      end
      return {c0, c1};
    end
    case (code)
      CODE_YO_UC: return {"Y", "o"};
      CODE_YO_LC: return {"y", "o"};
      CODE_DASH:  return {CHR_DASH, 8'h00};
      default:    return {CHR_SPACE, 8'h00};
    endcase
  endfunction

  task automatic put_char(input logic [7:0] c);
    cut_beat_t beat;
    if (char_count < MAX_CHARS) begin
      beat.chr  = c;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
      char_count++;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [15:0] latin;
    cut_beat_t   beat;
    if (held_valid) begin
      if (b[7]) begin
        latin      = latin_for_code({held_byte, b});
        held_valid = 1'b0;
        held_byte  = 8'h00;
        put_char(latin[15:8]);
        if (latin[7:0] != 8'h00) begin
          put_char(latin[7:0]);
        end
        return;
      end
      put_char(held_byte);
      held_valid = 1'b0;
      held_byte  = 8'h00;
    end
    if (b == CHR_END) begin
      beat.chr  = CHR_END;
      beat.last = 1'b1;
      pending_chars.push_back(beat);
      char_count = 0;
    end else if (b[7]) begin
      held_byte  = b;
      held_valid = 1'b1;
    end else begin
      put_char(b);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_byte(b);
  endtask

  task automatic send_pair(input logic [15:0] code);
    send_byte(code[15:8]);
    send_byte(code[7:0]);
  endtask

  task automatic pick_idling();
    gaps_on     = ($urandom_range(0, 3) != 0);
    stall_level = $urandom_range(0, 3);
  endtask

  task automatic send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(1, 8'h7F)));
    end else if (pick < 75) begin
      case ($urandom_range(0, 4))
        0, 1: send_pair({CODE_UC_LO[15:8],
                         8'($urandom_range(CODE_UC_LO[7:0], CODE_LCA_HI[7:0]))});
        2:    send_pair({CODE_LCB_LO[15:8],
                         8'($urandom_range(CODE_LCB_LO[7:0], CODE_LCB_HI[7:0]))});
        3:    send_pair($urandom_range(0, 1) ? CODE_YO_UC : CODE_YO_LC);
        default: send_pair(CODE_DASH);
      endcase
    end else if (pick < 88) begin
      send_pair({8'($urandom_range(8'h80, 8'hFF)), 8'($urandom_range(8'h80, 8'hFF))});
    end else begin
      send_byte(8'($urandom_range(8'h80, 8'hFF)));
    end
  endtask

  task automatic send_text_string(input int tokens);
    repeat (tokens) send_random_token();
    send_byte(CHR_END);
  endtask

  task automatic test_plain_bytes();
    gaps_on     = 1'b0;
    stall_level = 0;
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(CHR_END);
  endtask

  task automatic test_letter_pairs();
    stall_level = 2;
    send_pair(CODE_UC_LO);
    send_pair(16'hD096);
    send_pair(CODE_LCB_HI);
    send_pair(CODE_YO_UC);
    send_pair(CODE_YO_LC);
    send_pair(CODE_DASH);
    send_pair(16'hFFFF);
  endtask

  task automatic test_held_byte_cases();
    gaps_on = 1'b1;
    send_byte(8'hC3);
    send_byte(8'h41);
    send_byte(8'h80);
    send_byte(CHR_END);
  endtask

  task automatic test_empty_string();
    stall_level = 3;
    send_byte(CHR_END);
  endtask

  task automatic test_random_text();
    int stop_at;
    stop_at = items_sent + 650;
    while (items_sent < stop_at) begin
      pick_idling();
      send_text_string($urandom_range(0, 30));
    end
  endtask

  task automatic test_long_strings();
    int stop_at;
    stop_at = items_sent + 400;
    while (items_sent < stop_at) begin
      pick_idling();
      send_text_string($urandom_range(45, 70));
    end
  endtask

  task automatic test_byte_noise();
    int stop_at;
    stop_at = items_sent + 250;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 63) == 0) begin
        pick_idling();
      end
      if ($urandom_range(0, 15) == 0) begin
        send_byte(CHR_END);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    send_byte(CHR_END);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: char %h last %b", out_char, out_is_last);
        end
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.chr || out_is_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.chr, want.last, out_char, out_is_last);
          end
        end
      end
    end
    if (stall_pos == 4'd0) begin
      case (stall_level)
        0:       stall_pat = '0;
        1:       stall_pat = 16'($urandom) & 16'($urandom);
        2:       stall_pat = 16'($urandom) | 16'($urandom);
        default: stall_pat = 16'($urandom);
      endcase
    end
    out_stall <= stall_pat[stall_pos];
    stall_pos = stall_pos + 4'd1;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_letter_pairs();
    test_held_byte_cases();
    test_empty_string();
    test_random_text();
    test_long_strings();
    test_byte_noise();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cut_pkg.sv
rtl/cut_step.sv
rtl/cut_obuf.sv
rtl/cyrillic_utf8_transliterator.sv
tb/sv/tb_top.sv
